@@ sv/omac_pkg.sv @@
// shared types and constants of the offset masked alpha compositor
package omac_pkg;

	// sample and channel geometry
	localparam int CH       = 4;
	localparam int SAMPLE_W = 24;

	// stream packing of the slave side, lowest bit first
	localparam int BG_LSB     = 0;
	localparam int FG_LSB     = CH * SAMPLE_W;
	localparam int ALPHA_LSB  = 2 * CH * SAMPLE_W;
	localparam int ALPHA_W    = 17;
	localparam int MASK_LSB   = ALPHA_LSB + ALPHA_W;
	localparam int MASK_W     = 17;
	localparam int TDATA_IN_W = ((MASK_LSB + MASK_W + 7) / 8) * 8;

	// stream packing of the master side
	localparam int SIDX_W      = 24;
	localparam int TDATA_OUT_W = CH * SAMPLE_W + SIDX_W;
	localparam int TUSER_OUT_W = 2;

	// fixed-point one in Q1.15
	localparam logic [15:0] Q15_ONE = 16'd32768;
	localparam logic [12:0] MAX_DIM = 13'd4096;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] CFG_BG_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BG_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FG_WIDTH  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_FG_HEIGHT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_X   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_Y   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_OPACITY   = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_LAYOUT    = 3'd7;

	// queue between front and back
	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;
	localparam logic [QPTR_W:0] QFULL = (QPTR_W + 1)'(QDEPTH);

	// settings already clamped and split into fields
	typedef struct packed {
		logic [12:0]        bg_w;
		logic [12:0]        bg_h;
		logic [12:0]        fg_w;
		logic [12:0]        fg_h;
		logic signed [13:0] shift_x;
		logic signed [13:0] shift_y;
		logic [15:0]        op;
		logic [1:0]         bg_code;
		logic [1:0]         fg_code;
		logic [2:0]         mask_kind;
		logic               has_alpha;
	} cfg_t;

	// classified pixel handed from front to back
	typedef struct packed {
		logic [CH-1:0][SAMPLE_W-1:0] bg;
		logic [CH-1:0][SAMPLE_W-1:0] fg;
		logic [15:0]                 alpha;
		logic [15:0]                 mask;
		logic [11:0]                 src_x;
		logic [11:0]                 src_y;
		logic                        in_win;
		logic                        frame_end;
	} q_item_t;

	// finished result
	typedef struct packed {
		logic [SIDX_W-1:0]           src_index;
		logic [CH-1:0][SAMPLE_W-1:0] ch;
		logic                        blended;
		logic                        in_win;
		logic                        frame_end;
	} res_t;

endpackage

@@ sv/omac_front.sv @@
// front end: raster counters, window test, mask normalization, channel pick
module omac_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  omac_pkg::cfg_t                      cfg,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [omac_pkg::TDATA_IN_W-1:0]     in_data,
	input  logic                                q_full,
	output logic                                q_push,
	output omac_pkg::q_item_t                   q_item
);

	localparam logic [2:0] MK_NONE  = 3'd0;
	localparam logic [2:0] MK_BOOL  = 3'd1;
	localparam logic [2:0] MK_U8    = 3'd2;
	localparam logic [2:0] MK_U16   = 3'd3;
	localparam logic [2:0] MK_I16   = 3'd4;
	localparam logic [2:0] MK_FLOAT = 3'd5;

	logic [11:0]        col_q;
	logic [11:0]        row_q;
	logic               last_col;
	logic               last_row;
	logic signed [14:0] sx;
	logic signed [14:0] sy;
	logic               in_win;
	logic signed [16:0] alpha_raw;
	logic signed [16:0] mask_raw;
	logic               mask_pos;
	logic [15:0]        mask_n;
	logic [8:0]         m8;
	logic [16:0]        m16;
	logic [2:0]         bgc;
	logic [2:0]         fgc;

	function automatic logic [2:0] chan_count(input logic [1:0] code);
		unique case (code)
			2'd0: return 3'd1;
			2'd1: return 3'd3;
			default: return 3'd4;
		endcase
	endfunction

	// the queue has room, so a request can be taken
	assign in_ready = !q_full;
	assign q_push   = in_valid && !q_full;

	// raster position and mapped source position
	always_comb begin
		last_col = {1'b0, col_q} >= (cfg.bg_w - 13'd1);
		last_row = {1'b0, row_q} >= (cfg.bg_h - 13'd1);
		sx = $signed({3'b000, col_q}) + $signed({cfg.shift_x[13], cfg.shift_x});
		sy = $signed({3'b000, row_q}) + $signed({cfg.shift_y[13], cfg.shift_y});
		in_win = !sx[14] && !sy[14] &&
			(sx[13:0] < {1'b0, cfg.fg_w}) && (sy[13:0] < {1'b0, cfg.fg_h});
	end

	// mask normalized to q1.15 by the maximum of its kind
	always_comb begin
		mask_raw = $signed(in_data[omac_pkg::MASK_LSB +: omac_pkg::MASK_W]);
		mask_pos = !mask_raw[16] && (mask_raw != 17'sd0);
		m8  = {1'b0, mask_raw[7:0]} + 9'd1;
		m16 = {1'b0, mask_raw[15:0]} + 17'd1;
		mask_n = 16'd0;
		unique case (cfg.mask_kind)
			MK_NONE: mask_n = omac_pkg::Q15_ONE;
			MK_BOOL: mask_n = mask_pos ? omac_pkg::Q15_ONE : 16'd0;
			MK_U8: begin
				if (!mask_pos) mask_n = 16'd0;
				else if (mask_raw >= 17'sd255) mask_n = omac_pkg::Q15_ONE;
				else mask_n = {1'b0, mask_raw[7:0], 7'd0} + {8'd0, m8[8:1]};
			end
			MK_U16: begin
				if (!mask_pos) mask_n = 16'd0;
				else if (mask_raw >= 17'sd65535) mask_n = omac_pkg::Q15_ONE;
				else mask_n = m16[16:1];
			end
			MK_I16: begin
				if (!mask_pos) mask_n = 16'd0;
				else if (mask_raw >= 17'sd32767) mask_n = omac_pkg::Q15_ONE;
				else mask_n = {1'b0, mask_raw[14:0]} + {15'd0, mask_raw[14]};
			end
			MK_FLOAT: begin
				if (!mask_pos) mask_n = 16'd0;
				else if (mask_raw >= 17'sd32768) mask_n = omac_pkg::Q15_ONE;
				else mask_n = {1'b0, mask_raw[14:0]};
			end
			default: mask_n = 16'd0;
		endcase
	end

	// build the queue entry; unused channels carry zero on both layers
	always_comb begin
		int fi;
		alpha_raw = $signed(in_data[omac_pkg::ALPHA_LSB +: omac_pkg::ALPHA_W]);
		bgc = chan_count(cfg.bg_code);
		fgc = chan_count(cfg.fg_code);
		q_item = '0;
		for (int c = 0; c < omac_pkg::CH; c++) begin
			if (fgc == 3'd1) fi = 0;
			else if (3'(c) < fgc) fi = c;
			else fi = int'(fgc) - 1;
			if (3'(c) < bgc) begin
				q_item.bg[c] = in_data[omac_pkg::BG_LSB + c * omac_pkg::SAMPLE_W +:
					omac_pkg::SAMPLE_W];
				q_item.fg[c] = in_data[omac_pkg::FG_LSB + fi * omac_pkg::SAMPLE_W +:
					omac_pkg::SAMPLE_W];
			end
		end
		if (!cfg.has_alpha) q_item.alpha = omac_pkg::Q15_ONE;
		else if (!alpha_raw[16]) q_item.alpha = alpha_raw[15:0];
		else q_item.alpha = 16'd0;
		q_item.mask      = mask_n;
		q_item.src_x     = sx[11:0];
		q_item.src_y     = sy[11:0];
		q_item.in_win    = in_win;
		q_item.frame_end = last_col && last_row;
	end

	// raster counters advance with every accepted request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (q_push) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? 12'd0 : row_q + 12'd1;
			end else begin
				col_q <= col_q + 12'd1;
			end
		end
	end

endmodule

@@ sv/omac_fifo.sv @@
// short queue of classified pixels between front and back
module omac_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  omac_pkg::q_item_t push_item,
	output logic              full,
	input  logic              pop,
	output omac_pkg::q_item_t pop_item,
	output logic              empty
);

	omac_pkg::q_item_t             mem_q [omac_pkg::QDEPTH];
	logic [omac_pkg::QPTR_W-1:0]   wr_ptr_q;
	logic [omac_pkg::QPTR_W-1:0]   rd_ptr_q;
	logic [omac_pkg::QPTR_W:0]     count_q;

	assign full     = count_q == omac_pkg::QFULL;
	assign empty    = count_q == '0;
	assign pop_item = mem_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_item;
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

endmodule

@@ sv/omac_back.sv @@
// back end: factor product, source index and per-channel blend pipeline
module omac_back (
	input  logic              clk,
	input  logic              arst_n,
	input  omac_pkg::cfg_t    cfg,
	input  logic              q_empty,
	input  omac_pkg::q_item_t q_item,
	output logic              q_pop,
	output logic              out_valid,
	input  logic              out_ready,
	output omac_pkg::res_t    out_res
);

	localparam int CH = omac_pkg::CH;

	logic adv;

	// stage 1: alpha times mask, row times width, differences
	logic               v_s1;
	logic [30:0]        am_s1;
	logic [24:0]        imul_s1;
	logic [11:0]        sx_s1;
	logic signed [24:0] d_s1 [CH];
	logic [CH-1:0][23:0] bg_s1;
	logic               win_s1;
	logic               fend_s1;

	// stage 2: full product, source index
	logic               v_s2;
	logic [46:0]        p_s2;
	logic [23:0]        sidx_s2;
	logic signed [24:0] d_s2 [CH];
	logic [CH-1:0][23:0] bg_s2;
	logic               win_s2;
	logic               fend_s2;

	// stage 3: rounded and clamped factor
	logic               v_s3;
	logic [15:0]        a_s3;
	logic               blend_s3;
	logic [23:0]        sidx_s3;
	logic signed [24:0] d_s3 [CH];
	logic [CH-1:0][23:0] bg_s3;
	logic               win_s3;
	logic               fend_s3;

	// stage 4: factor times difference
	logic               v_s4;
	logic signed [41:0] prod_s4 [CH];
	logic               blend_s4;
	logic [23:0]        sidx_s4;
	logic [CH-1:0][23:0] bg_s4;
	logic               win_s4;
	logic               fend_s4;

	// stage 5: output register
	logic               v_s5;
	omac_pkg::res_t     res_s5;

	logic [47:0]        p_rnd;
	logic [17:0]        a_full;
	logic [24:0]        sidx_sum;

	// whole pipe moves when the output register is free or draining
	assign adv       = !v_s5 || out_ready;
	assign q_pop     = adv && !q_empty;
	assign out_valid = v_s5;
	assign out_res   = res_s5;

	always_comb begin
		p_rnd    = {1'b0, p_s2} + 48'd536870912;
		a_full   = p_rnd[47:30];
		sidx_sum = imul_s1 + {13'd0, sx_s1};
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s1 <= !q_empty;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// data path
	always_ff @(posedge clk) begin
		logic signed [41:0] t;
		if (adv) begin
			// stage 1
			am_s1   <= 31'(q_item.alpha * q_item.mask);
			imul_s1 <= 25'(q_item.src_y * cfg.fg_w);
			sx_s1   <= q_item.src_x;
			bg_s1   <= q_item.bg;
			win_s1  <= q_item.in_win;
			fend_s1 <= q_item.frame_end;
			for (int c = 0; c < CH; c++) begin
				d_s1[c] <= $signed({q_item.fg[c][23], q_item.fg[c]}) -
					$signed({q_item.bg[c][23], q_item.bg[c]});
			end

			// stage 2
			p_s2    <= 47'(am_s1) * 47'(cfg.op);
			sidx_s2 <= win_s1 ? sidx_sum[23:0] : 24'd0;
			bg_s2   <= bg_s1;
			win_s2  <= win_s1;
			fend_s2 <= fend_s1;
			for (int c = 0; c < CH; c++) d_s2[c] <= d_s1[c];

			// stage 3
			a_s3     <= (a_full > 18'd32768) ? omac_pkg::Q15_ONE : a_full[15:0];
			blend_s3 <= win_s2 && (a_full != 18'd0);
			sidx_s3  <= sidx_s2;
			bg_s3    <= bg_s2;
			win_s3   <= win_s2;
			fend_s3  <= fend_s2;
			for (int c = 0; c < CH; c++) d_s3[c] <= d_s2[c];

			// stage 4
			blend_s4 <= blend_s3;
			sidx_s4  <= sidx_s3;
			bg_s4    <= bg_s3;
			win_s4   <= win_s3;
			fend_s4  <= fend_s3;
			for (int c = 0; c < CH; c++) prod_s4[c] <= $signed({1'b0, a_s3}) * d_s3[c];

			// stage 5: bg plus floored, rounded share of the difference
			for (int c = 0; c < CH; c++) begin
				t = prod_s4[c] + 42'sd16384;
				res_s5.ch[c] <= blend_s4 ? bg_s4[c] + t[38:15] : bg_s4[c];
			end
			res_s5.blended   <= blend_s4;
			res_s5.in_win    <= win_s4;
			res_s5.src_index <= sidx_s4;
			res_s5.frame_end <= fend_s4;
		end
	end

endmodule

@@ sv/offset_masked_alpha_compositor.sv @@
// top level of the offset masked alpha compositor
//
// Slave stream s_*: one background pixel per request in raster order, with
// the foreground sample, alpha and mask already fetched for the mapped
// source position. Master stream m_*: one composited pixel per request,
// m_tlast marks the last pixel of a frame, m_tuser flags window and blend.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data, always
// ready; the user must write it only while the stream is idle, the block
// does not enforce this. Throughput is one pixel per clock while m_tready
// stays high. An accepted pixel is written into the front queue, then
// passes four pipeline stages (two multipliers for the factor, one for the
// blend) ahead of the output register that drives m_*.
// When m_tready is low the back pipeline holds as a whole; the 4-entry
// queue keeps taking pixels until it fills, then s_tready drops.
// Reset clears the raster counters, the queue and all valid bits, and
// returns the registers to sizes of 1, zero shift, full opacity and alpha
// present.
module offset_masked_alpha_compositor (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// configuration write channel
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [omac_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [omac_pkg::CFG_DATA_W-1:0]       cfg_data,
	// slave stream
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// bg_c0, bg_c1, bg_c2, bg_c3, fg_c0, fg_c1, fg_c2, fg_c3, alpha_in, mask_in
	input  logic [omac_pkg::TDATA_IN_W-1:0]       s_tdata,
	// master stream
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// out_c0, out_c1, out_c2, out_c3, src_index
	output logic [omac_pkg::TDATA_OUT_W-1:0]      m_tdata,
	// in_window, was_blended
	output logic [omac_pkg::TUSER_OUT_W-1:0]      m_tuser,
	// frame_end
	output logic                                  m_tlast
);

	logic [12:0]        bg_width_q;
	logic [12:0]        bg_height_q;
	logic [12:0]        fg_width_q;
	logic [12:0]        fg_height_q;
	logic signed [13:0] shift_x_q;
	logic signed [13:0] shift_y_q;
	logic [15:0]        opacity_q;
	logic [7:0]         layout_q;

	omac_pkg::cfg_t     cfg;
	omac_pkg::q_item_t  push_item;
	omac_pkg::q_item_t  pop_item;
	omac_pkg::res_t     res;
	logic               q_push;
	logic               q_pop;
	logic               q_full;
	logic               q_empty;

	assign cfg_ready = 1'b1;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bg_width_q  <= 13'd1;
			bg_height_q <= 13'd1;
			fg_width_q  <= 13'd1;
			fg_height_q <= 13'd1;
			shift_x_q   <= '0;
			shift_y_q   <= '0;
			opacity_q   <= omac_pkg::Q15_ONE;
			layout_q    <= 8'd128;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				omac_pkg::CFG_BG_WIDTH:  bg_width_q  <= cfg_data[12:0];
				omac_pkg::CFG_BG_HEIGHT: bg_height_q <= cfg_data[12:0];
				omac_pkg::CFG_FG_WIDTH:  fg_width_q  <= cfg_data[12:0];
				omac_pkg::CFG_FG_HEIGHT: fg_height_q <= cfg_data[12:0];
				omac_pkg::CFG_SHIFT_X:   shift_x_q   <= $signed(cfg_data[13:0]);
				omac_pkg::CFG_SHIFT_Y:   shift_y_q   <= $signed(cfg_data[13:0]);
				omac_pkg::CFG_OPACITY:   opacity_q   <= cfg_data;
				omac_pkg::CFG_LAYOUT:    layout_q    <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// clamped sizes and decoded layout
	always_comb begin
		if (bg_width_q == 13'd0) cfg.bg_w = 13'd1;
		else if (bg_width_q > omac_pkg::MAX_DIM) cfg.bg_w = omac_pkg::MAX_DIM;
		else cfg.bg_w = bg_width_q;
		if (bg_height_q == 13'd0) cfg.bg_h = 13'd1;
		else if (bg_height_q > omac_pkg::MAX_DIM) cfg.bg_h = omac_pkg::MAX_DIM;
		else cfg.bg_h = bg_height_q;
		cfg.fg_w = (fg_width_q > omac_pkg::MAX_DIM) ? omac_pkg::MAX_DIM : fg_width_q;
		cfg.fg_h = (fg_height_q > omac_pkg::MAX_DIM) ? omac_pkg::MAX_DIM : fg_height_q;
		cfg.shift_x   = shift_x_q;
		cfg.shift_y   = shift_y_q;
		cfg.op        = (opacity_q > omac_pkg::Q15_ONE) ? omac_pkg::Q15_ONE : opacity_q;
		cfg.bg_code   = layout_q[1:0];
		cfg.fg_code   = layout_q[3:2];
		cfg.mask_kind = layout_q[6:4];
		cfg.has_alpha = layout_q[7];
	end

	omac_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_data  (s_tdata),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_item   (push_item)
	);

	omac_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (q_pop),
		.pop_item  (pop_item),
		.empty     (q_empty)
	);

	omac_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.q_empty   (q_empty),
		.q_item    (pop_item),
		.q_pop     (q_pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (res)
	);

	// output packing
	assign m_tdata = {res.src_index, res.ch};
	assign m_tuser = {res.blended, res.in_win};
	assign m_tlast = res.frame_end;

endmodule
